// File: rtl/core/sd_card_init_sequencer_assert.svh
// Assertion helpers shared by the sequencer RTL.
// Each macro samples on the rising edge of clock and is idle during reset.
`ifndef SD_CARD_INIT_SEQUENCER_ASSERT_SVH
`define SD_CARD_INIT_SEQUENCER_ASSERT_SVH

// Same-cycle implication: cond holds -> prop holds.
`define SDI_ASSERT_IMPL(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication: cond holds -> prop holds on the following clock.
`define SDI_ASSERT_NEXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// File: rtl/core/sdi_pkg.sv
`timescale 1ns / 1ps
package sdi_pkg;

   // Sequence step codes
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_IDCLK  = 4'd1;
   localparam logic [3:0] ST_CMD0   = 4'd2;
   localparam logic [3:0] ST_CMD8   = 4'd3;
   localparam logic [3:0] ST_CMD55  = 4'd4;
   localparam logic [3:0] ST_ACMD41 = 4'd5;
   localparam logic [3:0] ST_CMD2   = 4'd6;
   localparam logic [3:0] ST_CMD3   = 4'd7;
   localparam logic [3:0] ST_CMD9   = 4'd8;
   localparam logic [3:0] ST_CMD7   = 4'd9;
   localparam logic [3:0] ST_XCLK   = 4'd10;

   // Request kinds
   localparam logic [2:0] KIND_IDLE  = 3'd0;
   localparam logic [2:0] KIND_CMD   = 3'd1;
   localparam logic [2:0] KIND_CLOCK = 3'd2;
   localparam logic [2:0] KIND_DONE  = 3'd3;
   localparam logic [2:0] KIND_FAIL  = 3'd4;

   // Input action codes
   localparam logic ACT_START    = 1'b0;
   localparam logic ACT_COMPLETE = 1'b1;

   // SD command numbers
   localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
   localparam logic [5:0] CMD_ALL_CID   = 6'd2;
   localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
   localparam logic [5:0] CMD_SELECT    = 6'd7;
   localparam logic [5:0] CMD_IF_COND   = 6'd8;
   localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
   localparam logic [5:0] CMD_OP_COND   = 6'd41;
   localparam logic [5:0] CMD_APP_CMD   = 6'd55;

   // Failure codes
   localparam logic [3:0] FAIL_NONE   = 4'd0;
   localparam logic [3:0] FAIL_IDCLK  = 4'd1;
   localparam logic [3:0] FAIL_CMD0   = 4'd2;
   localparam logic [3:0] FAIL_CMD55  = 4'd3;
   localparam logic [3:0] FAIL_ACMD41 = 4'd4;
   localparam logic [3:0] FAIL_NOTRDY = 4'd5;
   localparam logic [3:0] FAIL_CMD2   = 4'd6;
   localparam logic [3:0] FAIL_CMD3   = 4'd7;
   localparam logic [3:0] FAIL_CMD9   = 4'd8;
   localparam logic [3:0] FAIL_CMD7   = 4'd9;
   localparam logic [3:0] FAIL_XCLK   = 4'd10;

   // CSR indexes
   localparam logic [2:0] CSR_IDENT_DIV  = 3'd0;
   localparam logic [2:0] CSR_XFER_DIV   = 3'd1;
   localparam logic [2:0] CSR_RETRY_LIM  = 3'd2;
   localparam logic [2:0] CSR_OP_ARG     = 3'd3;
   localparam logic [2:0] CSR_IF_ARG     = 3'd4;

   // CSR reset values
   localparam logic [7:0]  RST_IDENT_DIV = 8'd63;
   localparam logic [7:0]  RST_XFER_DIV  = 8'd1;
   localparam logic [15:0] RST_RETRY_LIM = 16'd1000;
   localparam logic [31:0] RST_OP_ARG    = 32'h40FF_8000;
   localparam logic [11:0] RST_IF_ARG    = 12'h1AA;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;

   // One result word
   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  cmd_num;
      logic [31:0] cmd_arg;
      logic        expects_rsp;
      logic        long_rsp;
      logic        check_crc;
      logic        init_clocks;
      logic [7:0]  clk_div;
      logic [3:0]  fail_code;
   } rsp_type;

endpackage

// File: rtl/core/sd_card_init_sequencer.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake                 Payload
// req      in   req_tvalid/req_tready     req_tuser action, req_tdata ok + response
// rsp      out  rsp_tvalid/rsp_tready     rsp_tuser kind, rsp_tdata command fields
// csr      in   csr_valid/csr_ready       csr_index, csr_data
//
// One word per cycle while req_tready is high; it drops while the skid register is full.
// Each accepted word is decoded against the step register in a single pass and its
// result goes into the output register, or into the one-entry skid register when a
// result waits, so a second word can be taken then. Reset is synchronous and returns the
// sequence to idle with CSRs at their defaults. csr_ready is always high.
module sd_card_init_sequencer
   import sdi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] action
   input  logic                  req_tuser,
   // [0] completed_ok, [32:1] response_word, [39:33] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] request_kind
   output logic [2:0]            rsp_tuser,
   // [5:0] command_index, [37:6] command_argument, [38] expects_response,
   // [39] long_response, [40] check_crc, [41] send_init_clocks,
   // [49:42] clock_divisor, [53:50] failure_code, [55:54] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data
);

`include "sd_card_init_sequencer_assert.svh"

   logic [7:0]  ident_div_ff;
   logic [7:0]  xfer_div_ff;
   logic [15:0] retry_lim_ff;
   logic [31:0] op_arg_ff;
   logic [11:0] if_arg_ff;

   logic [3:0]  step_ff, step_in;
   logic [15:0] retry_ff, retry_in;
   logic [15:0] rca_ff, rca_in;

   logic        main_v_ff, skid_v_ff;
   rsp_type     main_ff, skid_ff;
   rsp_type     res;

   logic        accept, pop, ok, is_start;
   logic [31:0] resp;
   logic [15:0] limit, retry_inc;

   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign req_tready = !skid_v_ff;
   assign pop        = main_v_ff && rsp_tready;
   assign is_start   = (req_tuser == ACT_START);
   assign ok         = req_tdata[0];
   assign resp       = req_tdata[32:1];
   assign limit      = (retry_lim_ff == 16'd0) ? 16'd1 : retry_lim_ff;
   assign retry_inc  = retry_ff + 16'd1;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ident_div_ff <= RST_IDENT_DIV;
         xfer_div_ff  <= RST_XFER_DIV;
         retry_lim_ff <= RST_RETRY_LIM;
         op_arg_ff    <= RST_OP_ARG;
         if_arg_ff    <= RST_IF_ARG;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IDENT_DIV: ident_div_ff <= csr_data[7:0];
            CSR_XFER_DIV:  xfer_div_ff  <= csr_data[7:0];
            CSR_RETRY_LIM: retry_lim_ff <= csr_data[15:0];
            CSR_OP_ARG:    op_arg_ff    <= csr_data;
            CSR_IF_ARG:    if_arg_ff    <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // Step decode: next request and next state
   always_comb begin
      res      = '0;
      step_in  = step_ff;
      retry_in = retry_ff;
      rca_in   = rca_ff;
      if (is_start) begin
         retry_in    = '0;
         rca_in      = '0;
         res.kind    = KIND_CLOCK;
         res.clk_div = ident_div_ff;
         step_in     = ST_IDCLK;
      end else begin
         unique case (step_ff)
            ST_IDCLK: begin
               if (!ok) begin
                  res.kind = KIND_FAIL; res.fail_code = FAIL_IDCLK; step_in = ST_IDLE;
               end else begin
                  res.kind = KIND_CMD; res.cmd_num = CMD_GO_IDLE;
                  res.init_clocks = 1'b1; step_in = ST_CMD0;
               end
            end
            ST_CMD0: begin
               if (!ok) begin
                  res.kind = KIND_FAIL; res.fail_code = FAIL_CMD0; step_in = ST_IDLE;
               end else begin
                  res.kind = KIND_CMD; res.cmd_num = CMD_IF_COND;
                  res.cmd_arg = {20'd0, if_arg_ff};
                  res.expects_rsp = 1'b1; res.check_crc = 1'b1; step_in = ST_CMD8;
               end
            end
            // CMD8 failure is tolerated
            ST_CMD8: begin
               retry_in = '0;
               res.kind = KIND_CMD; res.cmd_num = CMD_APP_CMD;
               res.expects_rsp = 1'b1; res.check_crc = 1'b1; step_in = ST_CMD55;
            end
            ST_CMD55: begin
               if (!ok) begin
                  res.kind = KIND_FAIL; res.fail_code = FAIL_CMD55; step_in = ST_IDLE;
               end else begin
                  res.kind = KIND_CMD; res.cmd_num = CMD_OP_COND;
                  res.cmd_arg = op_arg_ff; res.expects_rsp = 1'b1; step_in = ST_ACMD41;
               end
            end
            // OCR busy bit set: card ready; else count a round and retry, failing once the retry limit is reached
            ST_ACMD41: begin
               if (!ok) begin
                  res.kind = KIND_FAIL; res.fail_code = FAIL_ACMD41; step_in = ST_IDLE;
               end else if (resp[31]) begin
                  res.kind = KIND_CMD; res.cmd_num = CMD_ALL_CID;
                  res.expects_rsp = 1'b1; res.long_rsp = 1'b1; res.check_crc = 1'b1;
                  step_in = ST_CMD2;
               end else begin
                  retry_in = retry_inc;
                  if (retry_inc >= limit) begin
                     res.kind = KIND_FAIL; res.fail_code = FAIL_NOTRDY; step_in = ST_IDLE;
                  end else begin
                     res.kind = KIND_CMD; res.cmd_num = CMD_APP_CMD;
                     res.expects_rsp = 1'b1; res.check_crc = 1'b1; step_in = ST_CMD55;
                  end
               end
            end
            ST_CMD2: begin
               if (!ok) begin
                  res.kind = KIND_FAIL; res.fail_code = FAIL_CMD2; step_in = ST_IDLE;
               end else begin
                  res.kind = KIND_CMD; res.cmd_num = CMD_SEND_RCA;
                  res.expects_rsp = 1'b1; res.check_crc = 1'b1; step_in = ST_CMD3;
               end
            end
            // capture the card address
            ST_CMD3: begin
               if (!ok) begin
                  res.kind = KIND_FAIL; res.fail_code = FAIL_CMD3; step_in = ST_IDLE;
               end else begin
                  rca_in = resp[31:16];
                  res.kind = KIND_CMD; res.cmd_num = CMD_SEND_CSD;
                  res.cmd_arg = {resp[31:16], 16'd0};
                  res.expects_rsp = 1'b1; res.long_rsp = 1'b1; res.check_crc = 1'b1;
                  step_in = ST_CMD9;
               end
            end
            ST_CMD9: begin
               if (!ok) begin
                  res.kind = KIND_FAIL; res.fail_code = FAIL_CMD9; step_in = ST_IDLE;
               end else begin
                  res.kind = KIND_CMD; res.cmd_num = CMD_SELECT;
                  res.cmd_arg = {rca_ff, 16'd0};
                  res.expects_rsp = 1'b1; res.check_crc = 1'b1; step_in = ST_CMD7;
               end
            end
            ST_CMD7: begin
               if (!ok) begin
                  res.kind = KIND_FAIL; res.fail_code = FAIL_CMD7; step_in = ST_IDLE;
               end else begin
                  res.kind = KIND_CLOCK; res.clk_div = xfer_div_ff; step_in = ST_XCLK;
               end
            end
            ST_XCLK: begin
               if (!ok) begin
                  res.kind = KIND_FAIL; res.fail_code = FAIL_XCLK;
               end else begin
                  res.kind = KIND_DONE;
               end
               step_in = ST_IDLE;
            end
            default: begin
               res.kind = KIND_IDLE;
               step_in  = ST_IDLE;
            end
         endcase
      end
   end

   // Sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ST_IDLE;
         retry_ff <= '0;
         rca_ff   <= '0;
      end else if (accept) begin
         step_ff  <= step_in;
         retry_ff <= retry_in;
         rca_ff   <= rca_in;
      end
   end

   // Output register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (pop || !main_v_ff) begin
         if (skid_v_ff) begin
            main_v_ff <= 1'b1;
            skid_v_ff <= accept;
         end else begin
            main_v_ff <= accept;
         end
      end else if (accept) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !main_v_ff) begin
         if (skid_v_ff) begin
            main_ff <= skid_ff;
            skid_ff <= res;
         end else begin
            main_ff <= res;
         end
      end else if (accept) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid = main_v_ff;
   assign rsp_tuser  = main_ff.kind;
   assign rsp_tdata  = {2'b00, main_ff.fail_code, main_ff.clk_div, main_ff.init_clocks,
                        main_ff.check_crc, main_ff.long_rsp, main_ff.expects_rsp,
                        main_ff.cmd_arg, main_ff.cmd_num};

   // Checks
   `SDI_ASSERT_IMPL(a_skid_behind_main, skid_v_ff, main_v_ff)
   `SDI_ASSERT_NEXT(a_start_to_idclk, accept && is_start, step_ff == ST_IDCLK)
   `SDI_ASSERT_NEXT(a_fail_to_idle, accept && (res.kind == KIND_FAIL), step_ff == ST_IDLE)
   `SDI_ASSERT_IMPL(a_fail_code_match, main_v_ff,
                    (main_ff.kind == KIND_FAIL) == (main_ff.fail_code != FAIL_NONE))

endmodule
